[rtl/trms_pkg.sv]
`timescale 1ns / 1ps
// Package for the timed relay measurement sequencer core.
// Holds field widths, register indexes, reset values and beat layouts.
// No dependencies.
package trms_pkg;

  // Field widths
  localparam int unsigned VoltW  = 15;
  localparam int unsigned CurW   = 16;
  localparam int unsigned PowW   = 16;
  localparam int unsigned StabW  = 16;
  localparam int unsigned TimeW  = 20;
  localparam int unsigned MsW    = 10;
  localparam int unsigned SecW   = 32;
  localparam int unsigned CfgW   = 20;
  localparam int unsigned CfgIdxW = 3;

  // Beat widths, padded to whole bytes
  localparam int unsigned InW  = 48;
  localparam int unsigned OutW = 88;

  localparam logic [MsW-1:0] MsLast = MsW'(999);

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_START_THR  = 3'd0,
    REG_STOP_THR   = 3'd1,
    REG_STABLE_MS  = 3'd2,
    REG_RELAY_OFF  = 3'd3,
    REG_RELAY_ON   = 3'd4,
    REG_SAMPLE_INT = 3'd5,
    REG_MIN_RUN    = 3'd6,
    REG_CUR_OFFSET = 3'd7
  } cfg_reg_e;

  // Register reset values
  localparam logic [VoltW-1:0] StartThrRst  = VoltW'(800);
  localparam logic [VoltW-1:0] StopThrRst   = VoltW'(800);
  localparam logic [StabW-1:0] StableMsRst  = StabW'(200);
  localparam logic [TimeW-1:0] RelayOffRst  = TimeW'(300000);
  localparam logic [TimeW-1:0] RelayOnRst   = TimeW'(90000);
  localparam logic [TimeW-1:0] SampleIntRst = TimeW'(10000);
  localparam logic [TimeW-1:0] MinRunRst    = TimeW'(80000);
  localparam logic [CurW-1:0]  CurOffRst    = 16'hFFFB;

  // Result beat, highest field first
  typedef struct packed {
    logic [3:0]       pad;
    logic [PowW-1:0]  sample_power;
    logic [CurW-1:0]  sample_current;
    logic [VoltW-1:0] sample_voltage;
    logic [SecW-1:0]  elapsed_seconds;
    logic             stopped;
    logic             sample_valid;
    logic             started;
    logic             relay_on;
    logic             measuring;
  } out_beat_t;

  // Saturating increment of a timer
  function automatic logic [TimeW-1:0] sat_inc20(input logic [TimeW-1:0] v);
    sat_inc20 = (v == '1) ? v : v + TimeW'(1);
  endfunction

endpackage

[rtl/timed_relay_measurement_sequencer_core.sv]
`timescale 1ns / 1ps
// Top level of the timed relay measurement sequencer: start qualification,
// relay cycling, periodic sampling and stop detection, one tick per beat.
// Depends on trms_pkg.
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+---------------------------------
//  s_axis   | in  | s_axis_tvalid/tready    | tick: button, voltage, current, power
//  m_axis   | out | m_axis_tvalid/tready    | result: flags, seconds, sample
//  cfg      | in  | cfg_we_i                | register index and data
//
// One input beat per clock cycle while m_axis is not stalled; every beat yields one result beat.
// The tick logic sits between the state registers and one result register,
// so a beat is accepted while the result register is empty or being drained.
// Reset clears the run state and the result valid flag and loads the register defaults; no clearing pass.
// A stall on m_axis holds the result and stops input acceptance.
module timed_relay_measurement_sequencer_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [0] button_pressed, [15:1] bus_voltage, [31:16] current_code,
  // [47:32] power_code
  input  logic [trms_pkg::InW-1:0]        s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] measuring, [1] relay_on, [2] started, [3] sample_valid, [4] stopped,
  // [36:5] elapsed_seconds, [51:37] sample_voltage, [67:52] sample_current,
  // [83:68] sample_power, [87:84] zero
  output logic [trms_pkg::OutW-1:0]       m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [trms_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [trms_pkg::CfgW-1:0]       cfg_data_i
);

  // Configuration registers
  logic [trms_pkg::VoltW-1:0] start_thr_q, stop_thr_q;
  logic [trms_pkg::StabW-1:0] stable_ms_q;
  logic [trms_pkg::TimeW-1:0] relay_off_q, relay_on_q, sample_int_q, min_run_q;
  logic [trms_pkg::CurW-1:0]  cur_off_q;

  // Run state
  logic                       run_q, run_d;
  logic                       relay_q, relay_d;
  logic [trms_pkg::StabW-1:0] stable_q, stable_d;
  logic [trms_pkg::TimeW-1:0] phase_q, phase_d;
  logic [trms_pkg::TimeW-1:0] since_q, since_d;
  logic [trms_pkg::TimeW-1:0] run_ms_q, run_ms_d;
  logic [trms_pkg::MsW-1:0]   msec_q, msec_d;
  logic [trms_pkg::SecW-1:0]  secs_q, secs_d;
  logic [trms_pkg::VoltW-1:0] last_v_q, last_v_d, prev_v_q, prev_v_d;

  // Result register
  logic                out_vld_q;
  trms_pkg::out_beat_t out_q, out_d;

  // Input fields
  logic                       btn;
  logic [trms_pkg::VoltW-1:0] volt;
  logic signed [trms_pkg::CurW-1:0] cur;
  logic [trms_pkg::PowW-1:0]  pow;

  logic                       s_acc;
  logic                       start_cond, start, active, toggle, sample, stop;
  logic                       relay_n;
  logic [trms_pkg::StabW-1:0] stable_inc;
  logic [trms_pkg::TimeW-1:0] phase_n, since_n, run_ms_n;
  logic [trms_pkg::MsW-1:0]   msec_n;
  logic [trms_pkg::SecW-1:0]  secs_n;
  logic signed [trms_pkg::CurW:0] cur_diff;
  logic [trms_pkg::CurW-1:0]  cur_sat;

  assign btn  = s_axis_tdata[0];
  assign volt = s_axis_tdata[15:1];
  assign cur  = $signed(s_axis_tdata[31:16]);
  assign pow  = s_axis_tdata[47:32];

  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  // Tick logic: qualify start, advance timers, cycle relay, sample, stop
  always_comb begin
    start_cond = !run_q && btn && (volt >= start_thr_q);
    stable_inc = (stable_q == '1) ? stable_q : stable_q + trms_pkg::StabW'(1);
    start      = start_cond && (stable_inc > stable_ms_q);
    stable_d   = (start_cond && !start) ? stable_inc : '0;
    active     = run_q || start;

    // Timers restart on the start tick, else advance before compare
    phase_n  = start ? '0 : trms_pkg::sat_inc20(phase_q);
    since_n  = start ? '0 : trms_pkg::sat_inc20(since_q);
    run_ms_n = start ? '0 : trms_pkg::sat_inc20(run_ms_q);
    if (start) begin
      msec_n = '0;
      secs_n = '0;
    end else if (msec_q == trms_pkg::MsLast) begin
      msec_n = '0;
      secs_n = (secs_q == '1) ? secs_q : secs_q + trms_pkg::SecW'(1);
    end else begin
      msec_n = msec_q + trms_pkg::MsW'(1);
      secs_n = secs_q;
    end

    // Relay phase
    toggle  = relay_q ? (phase_n >= relay_on_q) : (phase_n >= relay_off_q);
    relay_n = toggle ? !relay_q : relay_q;
    if (toggle) begin
      phase_n = '0;
    end

    // Offset-corrected current, saturated
    cur_diff = {cur[trms_pkg::CurW-1], cur} -
               {cur_off_q[trms_pkg::CurW-1], cur_off_q};
    if (cur_diff[trms_pkg::CurW] != cur_diff[trms_pkg::CurW-1]) begin
      cur_sat = cur_diff[trms_pkg::CurW] ? 16'h8000 : 16'h7FFF;
    end else begin
      cur_sat = cur_diff[trms_pkg::CurW-1:0];
    end

    sample = active && (since_n >= sample_int_q);
    stop   = sample && relay_n && (run_ms_n >= min_run_q) &&
             (volt <= stop_thr_q) && (last_v_q <= stop_thr_q);

    // Next state
    run_d    = run_q;
    relay_d  = relay_q;
    phase_d  = phase_q;
    since_d  = since_q;
    run_ms_d = run_ms_q;
    msec_d   = msec_q;
    secs_d   = secs_q;
    last_v_d = last_v_q;
    prev_v_d = prev_v_q;
    if (active) begin
      run_d    = 1'b1;
      relay_d  = relay_n;
      phase_d  = phase_n;
      since_d  = sample ? '0 : since_n;
      run_ms_d = run_ms_n;
      msec_d   = msec_n;
      secs_d   = secs_n;
    end
    if (sample) begin
      prev_v_d = last_v_q;
      last_v_d = volt;
    end
    if (stop) begin
      run_d    = 1'b0;
      relay_d  = 1'b0;
      phase_d  = '0;
      since_d  = '0;
      run_ms_d = '0;
      msec_d   = '0;
      secs_d   = '0;
    end

    // Result beat
    out_d                 = '0;
    out_d.measuring       = run_d;
    out_d.relay_on        = relay_d;
    out_d.started         = start;
    out_d.sample_valid    = sample;
    out_d.stopped         = stop;
    out_d.elapsed_seconds = active ? secs_n : '0;
    if (sample) begin
      out_d.sample_voltage = volt;
      out_d.sample_current = cur_sat;
      out_d.sample_power   = pow;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_thr_q  <= trms_pkg::StartThrRst;
      stop_thr_q   <= trms_pkg::StopThrRst;
      stable_ms_q  <= trms_pkg::StableMsRst;
      relay_off_q  <= trms_pkg::RelayOffRst;
      relay_on_q   <= trms_pkg::RelayOnRst;
      sample_int_q <= trms_pkg::SampleIntRst;
      min_run_q    <= trms_pkg::MinRunRst;
      cur_off_q    <= trms_pkg::CurOffRst;
    end else if (cfg_we_i) begin
      unique case (trms_pkg::cfg_reg_e'(cfg_idx_i))
        trms_pkg::REG_START_THR:  start_thr_q  <= cfg_data_i[trms_pkg::VoltW-1:0];
        trms_pkg::REG_STOP_THR:   stop_thr_q   <= cfg_data_i[trms_pkg::VoltW-1:0];
        trms_pkg::REG_STABLE_MS:  stable_ms_q  <= cfg_data_i[trms_pkg::StabW-1:0];
        trms_pkg::REG_RELAY_OFF:  relay_off_q  <= cfg_data_i;
        trms_pkg::REG_RELAY_ON:   relay_on_q   <= cfg_data_i;
        trms_pkg::REG_SAMPLE_INT: sample_int_q <= cfg_data_i;
        trms_pkg::REG_MIN_RUN:    min_run_q    <= cfg_data_i;
        trms_pkg::REG_CUR_OFFSET: cur_off_q    <= cfg_data_i[trms_pkg::CurW-1:0];
        default: ;
      endcase
    end
  end

  // Advance run state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q    <= 1'b0;
      relay_q  <= 1'b0;
      stable_q <= '0;
      phase_q  <= '0;
      since_q  <= '0;
      run_ms_q <= '0;
      msec_q   <= '0;
      secs_q   <= '0;
      last_v_q <= '0;
      prev_v_q <= '0;
    end else if (s_acc) begin
      run_q    <= run_d;
      relay_q  <= relay_d;
      stable_q <= stable_d;
      phase_q  <= phase_d;
      since_q  <= since_d;
      run_ms_q <= run_ms_d;
      msec_q   <= msec_d;
      secs_q   <= secs_d;
      last_v_q <= last_v_d;
      prev_v_q <= prev_v_d;
    end
  end

  // Result register: load on accept, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s_acc) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      out_q <= out_d;
    end
  end

`ifndef SYNTH
  // Relay is never energized outside a run
  a_relay_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !run_q |-> !relay_q)
    else $error("relay on while no run active");

  // A stop only comes with a sample and ends the run
  a_stop_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.stopped) |-> (out_q.sample_valid && !out_q.measuring))
    else $error("stop without sample or run still active");

  // A start beat that does not also stop leaves the block measuring
  a_start_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && start && !stop) |=> run_q)
    else $error("start did not enter a run");

  // Sample fields are zero on beats without a sample
  a_sample_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.sample_valid) |->
      (out_q.sample_voltage == '0 && out_q.sample_current == '0 &&
       out_q.sample_power == '0))
    else $error("sample fields set without sample");
`endif

endmodule
